[hdl/ufsef_pkg.sv]
// Shared types and constants for the union-find spanning-edge filter.
`default_nettype none

package ufsef_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // register index as decoded from paddr[2]
   localparam logic CSR_TILE_INDEX = 1'b0;

   typedef struct packed {
      logic       func;
      logic [3:0] row_a;
      logic [3:0] col_a;
      logic [3:0] row_b;
      logic [3:0] col_b;
   } req_type;

   typedef struct packed {
      logic [4:0] out_row_a;
      logic [4:0] out_col_a;
      logic [4:0] out_row_b;
      logic [4:0] out_col_b;
   } rsp_type;

   localparam logic FUNC_CLEAR = 1'b0;
   localparam logic FUNC_EDGE  = 1'b1;

   typedef enum logic [1:0] {
      CUR_HOLD   = 2'd0,
      CUR_CELL_A = 2'd1,
      CUR_CELL_B = 2'd2,
      CUR_PARENT = 2'd3
   } cur_sel_type;

   typedef enum logic [2:0] {
      WR_NONE     = 3'd0,
      WR_CLEAR    = 3'd1,
      WR_COMPRESS = 3'd2,
      WR_LOSER    = 3'd3,
      WR_WINNER   = 3'd4
   } wr_sel_type;

   typedef struct packed {
      logic        load_item;
      cur_sel_type cur_sel;
      logic        take_root;
      logic        side;
      wr_sel_type  wr_sel;
      logic        clr_step;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic in_range;
      logic is_root;
      logic at_root;
      logic roots_eq;
      logic clr_last;
   } status_type;

endpackage

`default_nettype wire

[hdl/ufsef_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ufsef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/ufsef_dpath.sv]
// Datapath: item register, root walk pointer, forest memory and result register.
`default_nettype none

module ufsef_dpath #(
   parameter int GRID_SIDE = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ufsef_pkg::req_type   req_data,
   input  wire ufsef_pkg::cmd_type   cmd,
   input  wire logic [1:0]           tile_index,
   output ufsef_pkg::status_type     status,
   output ufsef_pkg::rsp_type        rsp_data
);
   import ufsef_pkg::*;

   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int CW = $clog2(CELL_COUNT);
   localparam int SW = $clog2(CELL_COUNT + 1);
   localparam int EW = SW + CW;
   localparam logic [6:0]    SIDE_W    = 7'(GRID_SIDE);
   localparam logic [4:0]    SIDE_LO   = 5'(GRID_SIDE % 32);
   localparam logic [CW-1:0] LAST_CELL = CW'(CELL_COUNT - 1);

   req_type       item_ff;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] root_a_ff, root_b_ff;
   logic [SW-1:0] size_a_ff, size_b_ff;
   logic [CW-1:0] clr_cnt_ff;
   rsp_type       rsp_ff;

   logic [CW-1:0] cell_a, cell_b, root_sel;
   logic [EW-1:0] rd_data, wr_data;
   logic [CW-1:0] rd_parent, wr_addr;
   logic [SW-1:0] rd_size, size_sum;
   logic          wr_en, a_wins;
   logic [4:0]    roff, coff;

   assign cell_a = CW'(int'(item_ff.row_a) * GRID_SIDE + int'(item_ff.col_a));
   assign cell_b = CW'(int'(item_ff.row_b) * GRID_SIDE + int'(item_ff.col_b));

   assign rd_parent = rd_data[CW-1:0];
   assign rd_size   = rd_data[EW-1:CW];
   assign root_sel  = cmd.side ? root_b_ff : root_a_ff;
   assign a_wins    = size_a_ff > size_b_ff;
   assign size_sum  = size_a_ff + size_b_ff;

   assign status.func     = item_ff.func;
   assign status.in_range = ({3'b0, item_ff.row_a} < SIDE_W) && ({3'b0, item_ff.col_a} < SIDE_W)
                         && ({3'b0, item_ff.row_b} < SIDE_W) && ({3'b0, item_ff.col_b} < SIDE_W);
   assign status.is_root  = rd_parent == cur_ff;
   assign status.at_root  = cur_ff == root_sel;
   assign status.roots_eq = root_a_ff == root_b_ff;
   assign status.clr_last = clr_cnt_ff == LAST_CELL;

   always_comb begin
      case (cmd.cur_sel)
         CUR_CELL_A: cur_in = cell_a;
         CUR_CELL_B: cur_in = cell_b;
         CUR_PARENT: cur_in = rd_parent;
         default:    cur_in = cur_ff;
      endcase
   end

   // memory entry is {size, parent}; size only means something at a root
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cur_ff;
      wr_data = {rd_size, root_sel};
      case (cmd.wr_sel)
         WR_CLEAR: begin
            wr_addr = clr_cnt_ff;
            wr_data = {SW'(1), clr_cnt_ff};
         end
         WR_COMPRESS: begin
            wr_addr = cur_ff;
            wr_data = {rd_size, root_sel};
         end
         WR_LOSER: begin
            wr_addr = a_wins ? root_b_ff : root_a_ff;
            wr_data = a_wins ? {size_b_ff, root_a_ff} : {size_a_ff, root_b_ff};
         end
         WR_WINNER: begin
            wr_addr = a_wins ? root_a_ff : root_b_ff;
            wr_data = {size_sum, wr_addr};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   ufsef_ram #(
      .WIDTH (EW),
      .DEPTH (CELL_COUNT)
   ) u_forest (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   assign roff = tile_index[1] ? SIDE_LO : 5'd0;
   assign coff = tile_index[0] ? SIDE_LO : 5'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= status.clr_last ? '0 : clr_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      cur_ff <= cur_in;
      if (cmd.take_root) begin
         if (cmd.side) begin
            root_b_ff <= cur_ff;
            size_b_ff <= rd_size;
         end else begin
            root_a_ff <= cur_ff;
            size_a_ff <= rd_size;
         end
      end
      if (cmd.emit) begin
         rsp_ff.out_row_a <= {1'b0, item_ff.row_a} + roff;
         rsp_ff.out_col_a <= {1'b0, item_ff.col_a} + coff;
         rsp_ff.out_row_b <= {1'b0, item_ff.row_b} + roff;
         rsp_ff.out_col_b <= {1'b0, item_ff.col_b} + coff;
      end
   end

   assign rsp_data = rsp_ff;

   a_union_distinct: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == WR_LOSER || cmd.wr_sel == WR_WINNER) |-> (root_a_ff != root_b_ff))
      else $error("union of a set with itself");

   a_compress_not_root: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == WR_COMPRESS) |-> (cur_ff != root_sel))
      else $error("path compression rewrote a root");

   a_root_from_read: assert property (@(posedge clock) disable iff (reset)
      cmd.take_root |-> status.is_root)
      else $error("root captured from a non-root entry");

endmodule

`default_nettype wire

[hdl/ufsef_ctrl.sv]
// Controller: sequences clear sweep, root walks, compression, union and emit.
`default_nettype none

module ufsef_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire ufsef_pkg::status_type  status,
   output ufsef_pkg::cmd_type          cmd
);
   import ufsef_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE         = 10'b00_0000_0001,
      S_CLEAR        = 10'b00_0000_0010,
      S_START        = 10'b00_0000_0100,
      S_FIND_RD      = 10'b00_0000_1000,
      S_FIND_CHK     = 10'b00_0001_0000,
      S_COMP_RD      = 10'b00_0010_0000,
      S_COMP_CHK     = 10'b00_0100_0000,
      S_UNITE_LOSER  = 10'b00_1000_0000,
      S_UNITE_WINNER = 10'b01_0000_0000,
      S_EMIT         = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      side_b_ff, side_b_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      side_b_in     = side_b_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.cur_sel   = CUR_HOLD;
      cmd.wr_sel    = WR_NONE;
      cmd.side      = side_b_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_START;
            end
         end
         S_CLEAR: begin
            cmd.wr_sel   = WR_CLEAR;
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_START: begin
            if (status.func == FUNC_CLEAR) begin
               state_in = S_CLEAR;
            end else if (!status.in_range) begin
               state_in = S_IDLE;
            end else begin
               side_b_in   = 1'b0;
               cmd.cur_sel = CUR_CELL_A;
               state_in    = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (status.is_root) begin
               cmd.take_root = 1'b1;
               cmd.cur_sel   = side_b_ff ? CUR_CELL_B : CUR_CELL_A;
               state_in      = S_COMP_RD;
            end else begin
               cmd.cur_sel = CUR_PARENT;
               state_in    = S_FIND_RD;
            end
         end
         S_COMP_RD: begin
            if (!status.at_root) begin
               state_in = S_COMP_CHK;
            end else if (!side_b_ff) begin
               side_b_in   = 1'b1;
               cmd.cur_sel = CUR_CELL_B;
               state_in    = S_FIND_RD;
            end else if (status.roots_eq) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_UNITE_LOSER;
            end
         end
         S_COMP_CHK: begin
            cmd.wr_sel  = WR_COMPRESS;
            cmd.cur_sel = CUR_PARENT;
            state_in    = S_COMP_RD;
         end
         S_UNITE_LOSER: begin
            cmd.wr_sel = WR_LOSER;
            state_in   = S_UNITE_WINNER;
         end
         S_UNITE_WINNER: begin
            cmd.wr_sel = WR_WINNER;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reset starts with a sweep that builds the singleton forest
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         side_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_b_ff    <= side_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");

   a_result_not_dropped: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall))
      else $error("pending result dropped");

   a_union_after_walks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UNITE_LOSER) |-> $past(state_ff == S_COMP_RD) && side_b_ff)
      else $error("union before both root walks");

endmodule

`default_nettype wire

[hdl/union_find_spanning_edge_filter.sv]
// Union-find spanning-edge filter, top level. One item at a time.
// Edge item: load and check, then per cell a walk to its root and a compression of the path
// walked; then 2 union writes and 1 emit, which waits while the previous result is stalled;
// a dropped edge ends after the second compression. Every hop is a registered read from
// the forest memory. Clear item: load and check, then a sweep over all GRID_SIDE*GRID_SIDE
// cells; reset runs the sweep too, tile_index resets to 0.
`default_nettype none

module union_find_spanning_edge_filter #(
   parameter int GRID_SIDE = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire ufsef_pkg::req_type                   req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ufsef_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ufsef_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ufsef_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ufsef_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                      csr_pready
);
   import ufsef_pkg::*;

   logic [1:0] tile_ff;
   logic       tile_sel;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign tile_sel   = csr_paddr[2] == CSR_TILE_INDEX;
   assign csr_prdata = tile_sel ? {{(CSR_DATA_W-2){1'b0}}, tile_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_ff <= 2'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && tile_sel) begin
         tile_ff <= csr_pwdata[1:0];
      end
   end

   ufsef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ufsef_dpath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .tile_index (tile_ff),
      .status     (status),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[sim/tb_union_find_spanning_edge_filter.sv]
// Testbench for the union-find spanning-edge filter, checked against a local forest model.
module tb_union_find_spanning_edge_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import ufsef_pkg::*;

   localparam int SIDE = 16;
   localparam int CELLS = SIDE * SIDE;
   // covers one clear sweep, with margin
   localparam int SETTLE_CYCLES = 300;
   localparam logic [CSR_ADDR_W-1:0] TILE_ADDR = {CSR_TILE_INDEX, 2'b00};

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // local copy of the forest and the tile register
   logic [7:0] forest_parent [CELLS];
   logic [8:0] forest_size [CELLS];
   logic [1:0] tile_sel;
   rsp_type tree_edge_q[$];

   int fail_count = 0;
   int items_sent = 0;
   int edges_kept = 0;
   int edges_dropped = 0;
   int clears_sent = 0;
   int results_seen = 0;
   int src_gap_pct = 0;
   int sink_stall_pct = 0;
   int sink_hold_cycles = 0;
   bit [3:0] tiles_used = '0;

   union_find_spanning_edge_filter #(
      .GRID_SIDE(SIDE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void clear_forest_model();
      for (int c = 0; c < CELLS; c++) begin
         forest_parent[c] = 8'(c);
         forest_size[c] = 9'd1;
      end
   endfunction

   // root walk, then point every cell on the path straight at the root
   function automatic logic [7:0] find_and_compress(logic [7:0] start_cell);
      logic [7:0] root;
      logic [7:0] walk;
      logic [7:0] nxt;
      int steps;
      root = start_cell;
      steps = 0;
      while (steps < CELLS && forest_parent[root] != root) begin
         root = forest_parent[root];
         steps++;
      end
      walk = start_cell;
      steps = 0;
      while (walk != root && steps < CELLS) begin
         nxt = forest_parent[walk];
         forest_parent[walk] = root;
         walk = nxt;
         steps++;
      end
      return root;
   endfunction

   function automatic void predict_item(req_type item);
      logic [7:0] root_a;
      logic [7:0] root_b;
      logic [4:0] row_off;
      logic [4:0] col_off;
      rsp_type edge_out;
      if (item.func == FUNC_CLEAR) begin
         clear_forest_model();
         clears_sent++;
         return;
      end
      // 4-bit coordinates always lie inside the 16x16 grid
      root_a = find_and_compress({item.row_a, item.col_a});
      root_b = find_and_compress({item.row_b, item.col_b});
      if (root_a == root_b) begin
         edges_dropped++;
         return;
      end
      if (forest_size[root_a] > forest_size[root_b]) begin
         forest_parent[root_b] = root_a;
         forest_size[root_a] = forest_size[root_a] + forest_size[root_b];
      end else begin
         forest_parent[root_a] = root_b;
         forest_size[root_b] = forest_size[root_b] + forest_size[root_a];
      end
      row_off = 5'(SIDE * tile_sel[1]);
      col_off = 5'(SIDE * tile_sel[0]);
      edge_out.out_row_a = {1'b0, item.row_a} + row_off;
      edge_out.out_col_a = {1'b0, item.col_a} + col_off;
      edge_out.out_row_b = {1'b0, item.row_b} + row_off;
      edge_out.out_col_b = {1'b0, item.col_b} + col_off;
      tree_edge_q = {tree_edge_q, edge_out};
      edges_kept++;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_item(logic func, int ra, int ca, int rb, int cb);
      req_type item;
      item.func = func;
      item.row_a = 4'(ra);
      item.col_a = 4'(ca);
      item.row_b = 4'(rb);
      item.col_b = 4'(cb);
      return item;
   endfunction

   // neighbor edges dominate, as in a maze build; some far pairs, self edges, clears
   function automatic req_type random_item();
      req_type item;
      int roll;
      roll = $urandom_range(0, 999);
      item = make_item(FUNC_EDGE, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 15));
      if (roll < 7) begin
         item.func = FUNC_CLEAR;
      end else if (roll < 700) begin
         if ($urandom_range(0, 1)) begin
            item.row_b = item.row_a;
            item.col_b = (item.col_a == 4'd15) ? 4'd14 : item.col_a + 4'd1;
         end else begin
            item.col_b = item.col_a;
            item.row_b = (item.row_a == 4'd15) ? 4'd14 : item.row_a + 4'd1;
         end
         if ($urandom_range(0, 1))
            item = '{item.func, item.row_b, item.col_b, item.row_a, item.col_a};
      end else if (roll < 760) begin
         item.row_b = item.row_a;
         item.col_b = item.col_a;
      end
      return item;
   endfunction

   task automatic send_item(req_type item);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_item(item);
      items_sent++;
      if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
         gap = pick_gap();
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic source_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (tree_edge_q.size() != 0) @(posedge clock);
   endtask

   // a clear gives no result, so the block may still be sweeping
   task automatic settle_idle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= TILE_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_tile(logic [1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      settle_idle();
      csr_access(1'b1, CSR_DATA_W'(value), readback);
      tile_sel = value;
      tiles_used[value] = 1'b1;
      csr_access(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(value)) begin
         $display("%0t: tile_index readback expected %0d, actual %0h", $time, value, readback);
         fail_count++;
      end
   endtask

   function automatic void compare_coord(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : edge_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (tree_edge_q.size() == 0) begin
            $display("%0t: expected no item, actual %0d,%0d - %0d,%0d", $time,
                     rsp_data.out_row_a, rsp_data.out_col_a,
                     rsp_data.out_row_b, rsp_data.out_col_b);
            fail_count++;
         end else begin
            want = tree_edge_q.pop_front();
            compare_coord("out_row_a", want.out_row_a, rsp_data.out_row_a);
            compare_coord("out_col_a", want.out_col_a, rsp_data.out_col_a);
            compare_coord("out_row_b", want.out_row_b, rsp_data.out_row_b);
            compare_coord("out_col_b", want.out_col_b, rsp_data.out_col_b);
         end
      end
   end

   // receiver pacing; a long hold-off request takes priority
   initial begin : sink_pacing
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            sink_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0 || sink_stall_pct == 0) begin
            rsp_stall <= 1'b0;
            if (free_left > 0) free_left--;
         end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            rsp_stall <= 1'b1;
            stall_left = pick_gap() - 1;
         end else begin
            rsp_stall <= 1'b0;
            free_left = $urandom_range(0, 6);
         end
      end
   end

   task automatic test_directed();
      src_gap_pct = 0;
      sink_stall_pct = 0;
      send_item(make_item(FUNC_EDGE, 0, 0, 0, 1));     // tie: first root goes under
      send_item(make_item(FUNC_EDGE, 0, 1, 0, 0));     // closes a cycle
      send_item(make_item(FUNC_EDGE, 5, 5, 5, 5));     // same cell twice
      send_item(make_item(FUNC_EDGE, 0, 2, 0, 1));     // single cell joins larger set
      send_item(make_item(FUNC_EDGE, 0, 0, 15, 15));   // larger first set wins
      send_item(make_item(FUNC_EDGE, 15, 0, 0, 15));   // far apart cells
      send_item(make_item(FUNC_EDGE, 15, 0, 15, 15));
      send_item(make_item(FUNC_EDGE, 0, 15, 0, 2));
      send_item(make_item(FUNC_EDGE, 15, 15, 15, 15));
      send_item(make_item(FUNC_CLEAR, 15, 15, 15, 15));
      send_item(make_item(FUNC_EDGE, 0, 0, 0, 1));     // allowed again after clear
      send_item(make_item(FUNC_EDGE, 15, 15, 14, 15));
      send_item(make_item(FUNC_EDGE, 14, 15, 15, 15));
      // build equal sets to get deeper trees
      send_item(make_item(FUNC_EDGE, 1, 0, 1, 1));
      send_item(make_item(FUNC_EDGE, 2, 0, 2, 1));
      send_item(make_item(FUNC_EDGE, 1, 1, 2, 1));
      send_item(make_item(FUNC_EDGE, 3, 0, 3, 1));
      send_item(make_item(FUNC_EDGE, 3, 2, 3, 3));
      send_item(make_item(FUNC_EDGE, 3, 1, 3, 2));
      send_item(make_item(FUNC_EDGE, 1, 0, 3, 3));
      send_item(make_item(FUNC_EDGE, 0, 0, 3, 0));
      send_item(make_item(FUNC_EDGE, 2, 0, 15, 15));
      send_item(make_item(FUNC_EDGE, 15, 15, 1, 1));
      send_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
      source_idle();
   endtask

   task automatic test_tile_offsets();
      logic [1:0] order [4] = '{2'd3, 2'd0, 2'd2, 2'd1};
      foreach (order[i]) begin
         set_tile(order[i]);
         send_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
         repeat (10) send_item(random_item());
         source_idle();
      end
   endtask

   task automatic test_backpressure();
      src_gap_pct = 0;
      sink_stall_pct = 0;
      send_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
      @(posedge clock);
      sink_hold_cycles = 400;
      repeat (40) send_item(random_item());
      source_idle();
      // sender waits for every result before going on
      wait_for_results();
      repeat (20) send_item(random_item());
      source_idle();
   endtask

   task automatic test_random_phase(int count, int src_pct, int sink_pct, logic [1:0] tile);
      set_tile(tile);
      src_gap_pct = src_pct;
      sink_stall_pct = sink_pct;
      send_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
      repeat (count) send_item(random_item());
      source_idle();
   endtask

   initial begin : run_tests
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      clear_forest_model();
      tile_sel = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_tile_offsets();
      test_backpressure();
      test_random_phase(320, 0, 0, 2'd3);
      test_random_phase(320, 40, 0, 2'd1);
      test_random_phase(320, 0, 50, 2'd0);
      test_random_phase(370, 30, 30, 2'd2);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items: %0d tree edges, %0d cycle edges dropped, %0d clears.",
               items_sent, edges_kept, edges_dropped, clears_sent);
      $display("Tile positions used %b, %0d results checked, %0d mismatches.",
               tiles_used, results_seen, fail_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[union_find_spanning_edge_filter.f]
hdl/ufsef_pkg.sv
hdl/ufsef_ram.sv
hdl/ufsef_dpath.sv
hdl/ufsef_ctrl.sv
hdl/union_find_spanning_edge_filter.sv
sim/tb_union_find_spanning_edge_filter.sv
